@@ design/rcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpg_pkg: shared types and constants for the random cyclic permutation
// generator.
// ----------------------------------------------------------------------------
package rcpg_pkg;

  localparam int unsigned MaxEntries = 4096;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = IdxW + 1;

  localparam logic [63:0] SeedBase = 64'h9e3779b97f4a7c15;
  localparam int unsigned ShiftA   = 13;
  localparam int unsigned ShiftB   = 7;
  localparam int unsigned ShiftC   = 17;

  // Remainder unit: dividend bits retired per cycle.
  localparam int unsigned DivW      = 64;
  localparam int unsigned DivDigits = 4;
  localparam int unsigned DivSteps  = DivW / DivDigits;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  typedef enum logic [0:0] {
    OP_GENERATE = 1'b0,
    OP_READ     = 1'b1
  } rcpg_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_STEP,
    ST_DIV,
    ST_WAIT,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_LINK_RD,
    ST_LINK_WR,
    ST_DONE
  } rcpg_state_e;

  typedef struct packed {
    rcpg_op_e          opcode;
    logic [IdxW-1:0]   entry_index;
  } rcpg_cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]   successor;
    logic              table_ready;
  } rcpg_result_t;

  // Random-number generator control from the sequencer.
  typedef struct packed {
    logic load;
    logic step;
  } rcpg_rng_ctl_t;

endpackage

@@ design/rcpg_xorshift.sv @@
// ----------------------------------------------------------------------------
// rcpg_xorshift: 64-bit xorshift generator state
// Loads a seed or advances one xorshift step (13, 7, 17) per request.
// ----------------------------------------------------------------------------
module rcpg_xorshift (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcpg_pkg::rcpg_rng_ctl_t ctl_i,
  input  logic [63:0]           seed_i,
  output logic [63:0]           value_o
);

  logic [63:0] state_q, state_d;
  logic [63:0] t1, t2, t3;

  always_comb begin
    t1 = state_q ^ (state_q << rcpg_pkg::ShiftA);
    t2 = t1 ^ (t1 >> rcpg_pkg::ShiftB);
    t3 = t2 ^ (t2 << rcpg_pkg::ShiftC);
    priority if (ctl_i.load) begin
      state_d = seed_i;
    end else if (ctl_i.step) begin
      state_d = t3;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign value_o = state_q;

endmodule

@@ design/rcpg_mod_unit.sv @@
// ----------------------------------------------------------------------------
// rcpg_mod_unit: iterative remainder unit
// Computes a 64-bit dividend modulo a narrow divisor by restoring
// division, several dividend bits per cycle.
// ----------------------------------------------------------------------------
module rcpg_mod_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rcpg_pkg::DivW-1:0]   dividend_i,
  input  logic [rcpg_pkg::CntW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [rcpg_pkg::IdxW-1:0]   rem_o
);

  logic [rcpg_pkg::DivW-1:0]    dvd_q, dvd_d;
  logic [rcpg_pkg::CntW-1:0]    dsr_q;
  logic [rcpg_pkg::CntW-1:0]    rem_q, rem_d;
  logic [rcpg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [rcpg_pkg::CntW-1:0]    r;
  logic [rcpg_pkg::DivW-1:0]    d;

  // The remainder stays below the divisor, so it fits IdxW bits before
  // each shift and CntW bits after it.
  always_comb begin
    r = rem_q;
    d = dvd_q;
    for (int k = 0; k < rcpg_pkg::DivDigits; k++) begin
      r = {r[rcpg_pkg::IdxW-1:0], d[rcpg_pkg::DivW-1]};
      d = {d[rcpg_pkg::DivW-2:0], 1'b0};
      if (r >= dsr_q) begin
        r = r - dsr_q;
      end
    end
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = d;
      rem_d = r;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rcpg_pkg::DivCntW'(rcpg_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[rcpg_pkg::IdxW-1:0];

endmodule

@@ design/random_cyclic_permutation_generator.sv @@
// A read transaction reads the link table into a register when it is accepted;
// its result is registered in the read state. A generate transaction fills N
// order entries, runs N-1 swaps that each wait on the 4-bit-per-cycle remainder
// unit, then links N entries: one registered order-table read, then one link write.
// One transaction is in flight at a time; busy is high until its result strobe.
// Reset clears control state and sets the count to 4096; tables are not cleared.
// ----------------------------------------------------------------------------
// random_cyclic_permutation_generator: top level
// Sequencer, order and link tables, and the shuffle datapath that builds a
// single random cycle and answers successor reads.
// ----------------------------------------------------------------------------
module random_cyclic_permutation_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  rcpg_pkg::rcpg_cmd_t       cmd_i,
  output logic                      busy,
  output logic                      done_o,
  output rcpg_pkg::rcpg_result_t    result_o,
  input  logic                      cfg_we_i,
  input  logic [rcpg_pkg::CntW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = rcpg_pkg::IdxW;
  localparam int unsigned CntW = rcpg_pkg::CntW;

  rcpg_pkg::rcpg_state_e state_q, state_d;

  logic [CntW-1:0] entry_count_q;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] gen_count_q, gen_count_d;
  logic            gen_flag_q, gen_flag_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] rd_idx_q;
  logic            done_q, done_d;
  rcpg_pkg::rcpg_result_t result_q, result_d;

  logic [CntW-1:0] eff_count;
  logic            idx_last;
  logic [CntW-1:0] divisor;

  // Table control.
  logic            ord_we;
  logic [IdxW-1:0] ord_waddr, ord_wdata;
  logic            ord_re;
  logic [IdxW-1:0] ord_raddr_a, ord_raddr_b;
  logic [IdxW-1:0] ord_rd_a_q, ord_rd_b_q;
  logic            lnk_we, lnk_re;
  logic [IdxW-1:0] lnk_rd_q;

  logic [IdxW-1:0] order_mem [rcpg_pkg::MaxEntries];
  logic [IdxW-1:0] link_mem  [rcpg_pkg::MaxEntries];

  rcpg_pkg::rcpg_rng_ctl_t rng_ctl;
  logic [63:0]     rng_seed, rng_value;
  logic            mod_start, mod_done;
  logic [IdxW-1:0] mod_rem;

  always_comb begin
    if (entry_count_q < CntW'(2)) begin
      eff_count = CntW'(2);
    end else if (entry_count_q > CntW'(rcpg_pkg::MaxEntries)) begin
      eff_count = CntW'(rcpg_pkg::MaxEntries);
    end else begin
      eff_count = entry_count_q;
    end
  end

  assign idx_last = ({1'b0, idx_q} == (n_q - 1'b1));
  assign divisor  = {1'b0, idx_q} + 1'b1;
  assign rng_seed = rcpg_pkg::SeedBase ^ {{(64 - CntW - 2){1'b0}}, eff_count, 2'b00};

  rcpg_xorshift u_rng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rng_ctl),
    .seed_i  (rng_seed),
    .value_o (rng_value)
  );

  rcpg_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rng_value),
    .divisor_i  (divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcpg_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (cmd_i.opcode == rcpg_pkg::OP_READ) ? rcpg_pkg::ST_READ
                                                        : rcpg_pkg::ST_FILL;
        end
      end
      rcpg_pkg::ST_READ:    state_d = rcpg_pkg::ST_IDLE;
      rcpg_pkg::ST_FILL:    state_d = idx_last ? rcpg_pkg::ST_STEP : rcpg_pkg::ST_FILL;
      rcpg_pkg::ST_STEP:    state_d = rcpg_pkg::ST_DIV;
      rcpg_pkg::ST_DIV:     state_d = rcpg_pkg::ST_WAIT;
      rcpg_pkg::ST_WAIT:    state_d = mod_done ? rcpg_pkg::ST_SWAP_I : rcpg_pkg::ST_WAIT;
      rcpg_pkg::ST_SWAP_I:  state_d = rcpg_pkg::ST_SWAP_J;
      rcpg_pkg::ST_SWAP_J: begin
        state_d = (idx_q == IdxW'(1)) ? rcpg_pkg::ST_LINK_RD : rcpg_pkg::ST_STEP;
      end
      rcpg_pkg::ST_LINK_RD: state_d = rcpg_pkg::ST_LINK_WR;
      rcpg_pkg::ST_LINK_WR: state_d = idx_last ? rcpg_pkg::ST_DONE : rcpg_pkg::ST_LINK_RD;
      rcpg_pkg::ST_DONE:    state_d = rcpg_pkg::ST_IDLE;
      default:              state_d = rcpg_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    n_d         = n_q;
    gen_count_d = gen_count_q;
    gen_flag_d  = gen_flag_q;
    idx_d       = idx_q;
    j_d         = j_q;
    done_d      = 1'b0;
    result_d    = result_q;
    ord_we      = 1'b0;
    ord_waddr   = idx_q;
    ord_wdata   = idx_q;
    ord_re      = 1'b0;
    ord_raddr_a = idx_q;
    ord_raddr_b = idx_q;
    lnk_we      = 1'b0;
    lnk_re      = 1'b0;
    rng_ctl     = '0;
    mod_start   = 1'b0;
    unique case (state_q)
      rcpg_pkg::ST_IDLE: begin
        lnk_re = start;
        if (start && cmd_i.opcode == rcpg_pkg::OP_GENERATE) begin
          n_d          = eff_count;
          idx_d        = '0;
          rng_ctl.load = 1'b1;
        end
      end
      rcpg_pkg::ST_READ: begin
        done_d               = 1'b1;
        result_d.table_ready = gen_flag_q;
        if (gen_flag_q && ({1'b0, rd_idx_q} < gen_count_q)) begin
          result_d.successor = lnk_rd_q;
        end else begin
          result_d.successor = '0;
        end
      end
      rcpg_pkg::ST_FILL: begin
        ord_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_last) begin
          idx_d = idx_q;
        end
      end
      rcpg_pkg::ST_STEP: begin
        rng_ctl.step = 1'b1;
      end
      rcpg_pkg::ST_DIV: begin
        mod_start = 1'b1;
      end
      rcpg_pkg::ST_WAIT: begin
        if (mod_done) begin
          j_d         = mod_rem;
          ord_re      = 1'b1;
          ord_raddr_b = mod_rem;
        end
      end
      rcpg_pkg::ST_SWAP_I: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rd_b_q;
      end
      rcpg_pkg::ST_SWAP_J: begin
        ord_we    = 1'b1;
        ord_waddr = j_q;
        ord_wdata = ord_rd_a_q;
        idx_d     = (idx_q == IdxW'(1)) ? '0 : idx_q - 1'b1;
      end
      rcpg_pkg::ST_LINK_RD: begin
        ord_re      = 1'b1;
        ord_raddr_b = idx_last ? '0 : idx_q + 1'b1;
      end
      rcpg_pkg::ST_LINK_WR: begin
        lnk_we = 1'b1;
        if (!idx_last) begin
          idx_d = idx_q + 1'b1;
        end
      end
      rcpg_pkg::ST_DONE: begin
        gen_count_d          = n_q;
        gen_flag_d           = 1'b1;
        done_d               = 1'b1;
        result_d.successor   = '0;
        result_d.table_ready = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rcpg_pkg::ST_IDLE;
      entry_count_q <= CntW'(rcpg_pkg::MaxEntries);
      gen_count_q   <= '0;
      gen_flag_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_count_q <= gen_count_d;
      gen_flag_q  <= gen_flag_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    j_q      <= j_d;
    result_q <= result_d;
    if (start && !busy) begin
      rd_idx_q <= cmd_i.entry_index;
    end
  end

  // Order table: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd_a_q <= order_mem[ord_raddr_a];
      ord_rd_b_q <= order_mem[ord_raddr_b];
    end
  end

  // Link table: written while linking, read by read transactions.
  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      link_mem[ord_rd_a_q] <= ord_rd_b_q;
    end
    if (lnk_re) begin
      lnk_rd_q <= link_mem[cmd_i.entry_index];
    end
  end

  assign busy     = (state_q != rcpg_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // A result strobe always comes with the block back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == rcpg_pkg::ST_IDLE))
    else $error("result strobe while the sequencer is still active");

  // The swap partner never lies beyond the current index.
  a_partner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcpg_pkg::ST_WAIT && mod_done) |-> ({1'b0, mod_rem} < divisor))
    else $error("swap partner out of range");

  // The readiness flag in a result matches the generated state.
  a_ready_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.table_ready == gen_flag_q))
    else $error("table_ready disagrees with the generated state");

  // A generation always runs on a count within the supported range.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcpg_pkg::ST_FILL) |->
      (n_q >= CntW'(2) && n_q <= CntW'(rcpg_pkg::MaxEntries)))
    else $error("generation count out of range");
`endif

endmodule

@@ sim/tb_random_cyclic_permutation_generator.sv @@
// ----------------------------------------------------------------------------
// tb_random_cyclic_permutation_generator: self-checking testbench
// A directed table covers the reads before generation, the clamped and
// extreme entry counts, and reads past the cycle or after a count change.
// Random phases then reprogram the count and send generates and successor
// reads in bursts. Results are checked against typed rows or a local shuffle model.
// ----------------------------------------------------------------------------
module tb_random_cyclic_permutation_generator;

  localparam int unsigned IdxW       = rcpg_pkg::IdxW;
  localparam int unsigned CntW       = rcpg_pkg::CntW;
  localparam int unsigned MaxEntries = rcpg_pkg::MaxEntries;

  localparam int NumDirected = 24;
  localparam int RandomItems = 120;
  localparam int MaxReports  = 10;

  localparam rcpg_pkg::rcpg_result_t NotReady   = '{successor: '0, table_ready: 1'b0};
  localparam rcpg_pkg::rcpg_result_t ReadyEmpty = '{successor: '0, table_ready: 1'b1};

  typedef enum logic {
    ROW_CONFIG,
    ROW_COMMAND
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CntW-1:0]        count;
    rcpg_pkg::rcpg_op_e     op;
    logic [IdxW-1:0]        idx;
    bit                     typed;
    rcpg_pkg::rcpg_result_t want;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  rcpg_pkg::rcpg_cmd_t    cmd_i       = '0;
  logic                   busy;
  logic                   done_o;
  rcpg_pkg::rcpg_result_t result_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CntW-1:0]        cfg_wdata_i = '0;

  // Shuffle model state.
  logic [IdxW-1:0]   model_order [MaxEntries];
  logic [IdxW-1:0]   model_link  [MaxEntries];
  logic [63:0]       model_rng;
  bit                model_ready;
  int unsigned       model_gen_count;
  logic [CntW-1:0]   model_count;

  rcpg_pkg::rcpg_result_t link_results_due [$];

  int unsigned       mismatch_count = 0;
  int unsigned       results_seen   = 0;
  int unsigned       n_generate     = 0;
  int unsigned       n_read         = 0;
  int unsigned       n_read_hits    = 0;
  int unsigned       n_config       = 0;
  int unsigned       largest_cycle  = 0;
  int unsigned       burst_left     = 0;
  bit                start_held     = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd0,    1'b1, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd4095, 1'b1, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd4095, 1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd0,    1'b0, NotReady},
    '{ROW_CONFIG,  13'd0,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_GENERATE, 12'd4095, 1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd1,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd2,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd4095, 1'b1, ReadyEmpty},
    '{ROW_CONFIG,  13'd1,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd1,    1'b0, NotReady},
    '{ROW_CONFIG,  13'd5,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd3,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd4,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd3,    1'b0, NotReady},
    '{ROW_CONFIG,  13'd8191, rcpg_pkg::OP_GENERATE, 12'd0,    1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_GENERATE, 12'd0,    1'b1, ReadyEmpty},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd4095, 1'b0, NotReady},
    '{ROW_COMMAND, 13'd0,    rcpg_pkg::OP_READ,     12'd2048, 1'b0, NotReady}
  };

  random_cyclic_permutation_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the model and returns the result it should give.
  function automatic rcpg_pkg::rcpg_result_t predict_link(input rcpg_pkg::rcpg_cmd_t c);
    rcpg_pkg::rcpg_result_t r;
    int unsigned     n;
    int unsigned     k;
    int unsigned     j;
    logic [IdxW-1:0] t;
    r = '0;
    if (c.opcode == rcpg_pkg::OP_GENERATE) begin
      n = model_count;
      if (n < 2) n = 2;
      if (n > MaxEntries) n = MaxEntries;
      for (k = 0; k < n; k++) model_order[k] = IdxW'(k);
      model_rng = rcpg_pkg::SeedBase ^ 64'(n * 4);
      for (k = n - 1; k > 0; k--) begin
        model_rng = model_rng ^ (model_rng << rcpg_pkg::ShiftA);
        model_rng = model_rng ^ (model_rng >> rcpg_pkg::ShiftB);
        model_rng = model_rng ^ (model_rng << rcpg_pkg::ShiftC);
        j = int'(model_rng % 64'(k + 1));
        t = model_order[k];
        model_order[k] = model_order[j];
        model_order[j] = t;
      end
      for (k = 0; k < n; k++) begin
        model_link[model_order[k]] = model_order[(k + 1 == n) ? 0 : k + 1];
      end
      model_gen_count = n;
      model_ready = 1'b1;
    end else if (model_ready && c.entry_index < model_gen_count) begin
      r.successor = model_link[c.entry_index];
    end
    r.table_ready = model_ready;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  // Results cannot be held off, so each strobe is checked on the edge that ends it.
  always @(posedge clk_i) begin
    rcpg_pkg::rcpg_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (link_results_due.size() == 0) begin
        note_failure($sformatf("result with nothing pending: successor %0d ready %0b",
                               result_o.successor, result_o.table_ready));
      end else begin
        want = link_results_due.pop_front();
        if (result_o.successor !== want.successor)
          note_failure($sformatf("successor: expected %0d, got %0d",
                                 want.successor, result_o.successor));
        if (result_o.table_ready !== want.table_ready)
          note_failure($sformatf("table_ready: expected %0b, got %0b",
                                 want.table_ready, result_o.table_ready));
      end
    end
  end

  // Holds start high until the transaction is taken; start stays high on return.
  task automatic send_cmd(input rcpg_pkg::rcpg_op_e op, input logic [IdxW-1:0] idx,
                          input bit typed, input rcpg_pkg::rcpg_result_t want);
    rcpg_pkg::rcpg_cmd_t    c;
    rcpg_pkg::rcpg_result_t predicted;
    c.opcode      = op;
    c.entry_index = idx;
    start  <= 1'b1;
    cmd_i  <= c;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (op == rcpg_pkg::OP_READ) begin
      n_read++;
      if (model_ready && idx < model_gen_count) n_read_hits++;
    end else begin
      n_generate++;
    end
    predicted = predict_link(c);
    if (op == rcpg_pkg::OP_GENERATE && model_gen_count > largest_cycle)
      largest_cycle = model_gen_count;
    link_results_due.push_back(typed ? want : predicted);
  endtask

  task automatic pause_between();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      start_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end
  endtask

  task automatic drain();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
    while (link_results_due.size() != 0) @(posedge clk_i);
  endtask

  // The count register may only change while no transaction is in flight.
  task automatic write_count(input logic [CntW-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_count = v;
    n_config++;
  endtask

  initial begin
    int unsigned        row;
    int unsigned        k;
    int unsigned        phase_items;
    int unsigned        random_items;
    int unsigned        sel;
    bit                 gen_first;
    logic [CntW-1:0]    v;
    rcpg_pkg::rcpg_op_e op;
    logic [IdxW-1:0]    idx;

    model_ready     = 1'b0;
    model_gen_count = 0;
    model_count     = CntW'(MaxEntries);
    model_rng       = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < NumDirected; row++) begin
      if (directed_rows[row].kind == ROW_CONFIG) begin
        write_count(directed_rows[row].count);
      end else begin
        send_cmd(directed_rows[row].op, directed_rows[row].idx,
                 directed_rows[row].typed, directed_rows[row].want);
        pause_between();
      end
    end

    // Random phases: a new count, usually a generate, then mostly in-range reads.
    random_items = 0;
    while (random_items < RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) v = CntW'($urandom_range(0, 1));
      else if (sel < 18) v = CntW'($urandom_range(65, 400));
      else v = CntW'($urandom_range(2, 64));
      write_count(v);
      gen_first   = ($urandom_range(0, 99) < 85);
      phase_items = $urandom_range(8, 20);
      for (k = 0; k < phase_items; k++) begin
        if ((k == 0 && gen_first) || (k > 0 && $urandom_range(0, 99) < 10))
          op = rcpg_pkg::OP_GENERATE;
        else
          op = rcpg_pkg::OP_READ;
        if (op == rcpg_pkg::OP_READ && $urandom_range(0, 99) < 85)
          idx = IdxW'($urandom_range(0, model_gen_count - 1));
        else
          idx = IdxW'($urandom_range(0, MaxEntries - 1));
        send_cmd(op, idx, 1'b0, NotReady);
        pause_between();
        random_items++;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results: %0d generates (largest cycle %0d entries), %0d reads",
             results_seen, n_generate, largest_cycle, n_read);
    $display("%0d reads landed inside the cycle; %0d count writes; %0d mismatches",
             n_read_hits, n_config, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS random_cyclic_permutation_generator");
    end else begin
      $display("FAIL random_cyclic_permutation_generator");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still pending", link_results_due.size());
    $display("FAIL random_cyclic_permutation_generator");
    $finish;
  end

endmodule

@@ random_cyclic_permutation_generator.f @@
design/rcpg_pkg.sv
design/rcpg_xorshift.sv
design/rcpg_mod_unit.sv
design/random_cyclic_permutation_generator.sv
sim/tb_random_cyclic_permutation_generator.sv
